### sv/assert_macros.svh
// Assertion helpers shared by the meter modules.
// Every user must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define CRPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define CRPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/crpm_pkg.sv
`timescale 1ns / 1ps
package crpm_pkg;

  // Converter scaling: current = 125 * (((s * 3300) >> 10) - 1650)
  localparam int ADC_W      = 10;
  localparam int ADC_GAIN   = 3300;
  localparam int ADC_SHIFT  = 10;
  localparam int ADC_OFFSET = 1650;
  localparam int PROD_W     = 22;
  localparam int SCALED_W   = 13;
  localparam int CUR_GAIN   = 125;
  localparam int CUR_MUL_W  = 21;
  localparam int CUR_W      = 19;

  // Square and root widths (|current| <= 206250)
  localparam int SQ_W   = 36;
  localparam int MEAN_W = 36;
  localparam int ROOT_W = 18;
  localparam int PEAK_W = 18;

  // Divide by 100 as multiply by ceil(2^26 / 100), exact below 2^18
  localparam int DIV100_MUL   = 671089;
  localparam int DIV100_SHIFT = 26;
  localparam int RECIP_W      = 20;
  localparam int MUL_W        = PEAK_W + RECIP_W;

  // Result field widths
  localparam int PEAK_OUT_W = 11;
  localparam int RMS_OUT_W  = 12;

  // Block-end queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [ADC_W-1:0] sample;
    logic             last;
  } crpm_in_t;

  typedef struct packed {
    logic                  flow_dir;
    logic                  pk_dir;
    logic [PEAK_OUT_W-1:0] pk_amps;
    logic [RMS_OUT_W-1:0]  rms_current;
  } crpm_out_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } crpm_q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_ROOT,
    BK_SCALE,
    BK_HOLD
  } crpm_bk_state_t;

endpackage

### sv/crpm_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crpm_queue #(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rdata,
  output crpm_pkg::crpm_q_stat_t stat
);

  logic [WIDTH-1:0]                 mem_r [crpm_pkg::QDEPTH];
  logic [crpm_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [crpm_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [crpm_pkg::QCNT_W-1:0]      count_r;
  logic                             do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign rdata      = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `CRPM_ASSERT(a_no_overflow, push |-> (count_r != crpm_pkg::QCNT_W'(crpm_pkg::QDEPTH)), "queue overflow")
  `CRPM_ASSERT(a_level_bound, count_r <= crpm_pkg::QCNT_W'(crpm_pkg::QDEPTH), "queue level out of range")

endmodule

### sv/crpm_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crpm_front #(
  parameter int MAX_BLOCK = 1024,
  parameter int CNT_W     = 11,
  parameter int SUM_W     = 47,
  parameter int JOB_W     = 78
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  crpm_pkg::crpm_in_t     in_data,
  input  crpm_pkg::crpm_q_stat_t q_stat,
  output logic                   job_push,
  output logic [JOB_W-1:0]       job_data
);

  localparam int TALLY_W = CNT_W + 1;
  localparam int QEND_W  = crpm_pkg::QCNT_W;

  logic                   accept;
  logic                   in_end;
  logic [CNT_W-1:0]       in_cnt_r;

  logic [crpm_pkg::PROD_W-1:0]          s1_prod;
  logic signed [crpm_pkg::SCALED_W-1:0] s1_scaled;
  logic                                 s1_v_r, s1_end_r;
  logic signed [crpm_pkg::SCALED_W-1:0] s1_scaled_r;

  logic signed [crpm_pkg::CUR_MUL_W-1:0] s2_cur_full;
  logic                                  s2_v_r, s2_end_r;
  logic signed [crpm_pkg::CUR_W-1:0]     s2_cur_r;

  logic signed [2*crpm_pkg::CUR_W-1:0]   s3_sq_full;
  logic                                  s3_v_r, s3_end_r;
  logic signed [crpm_pkg::CUR_W-1:0]     s3_cur_r;
  logic [crpm_pkg::SQ_W-1:0]             s3_sq_r;

  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic signed [TALLY_W-1:0]    tally_r, tally_nxt;
  logic [crpm_pkg::PEAK_W-1:0]  peak_r, peak_nxt;
  logic                         psign_r, psign_nxt;
  logic signed [crpm_pkg::CUR_W:0] s3_neg;
  logic                         pos_gt, neg_gt;
  logic [QEND_W-1:0]            ends_in_flight;
  logic [QEND_W-1:0]            credit;

  // credit: queued block ends plus those still in the pipe
  assign ends_in_flight = QEND_W'(s1_end_r) + QEND_W'(s2_end_r) + QEND_W'(s3_end_r);
  assign credit         = q_stat.count + ends_in_flight;
  assign in_full        = (credit >= QEND_W'(crpm_pkg::QDEPTH));
  assign accept         = in_push && !in_full;

  // block end known at entry: marked last or block at full length
  assign in_end = in_data.last || (in_cnt_r == CNT_W'(MAX_BLOCK - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r <= '0;
    end else if (accept) begin
      in_cnt_r <= in_end ? '0 : in_cnt_r + 1'b1;
    end
  end

  // stage 1: converter gain and offset
  assign s1_prod   = crpm_pkg::PROD_W'(in_data.sample) * crpm_pkg::PROD_W'(crpm_pkg::ADC_GAIN);
  assign s1_scaled = $signed({1'b0, s1_prod[crpm_pkg::PROD_W-1:crpm_pkg::ADC_SHIFT]})
                   - $signed(crpm_pkg::SCALED_W'(crpm_pkg::ADC_OFFSET));

  // stage 2: current gain
  assign s2_cur_full = $signed(crpm_pkg::CUR_MUL_W'(s1_scaled_r))
                     * $signed(crpm_pkg::CUR_MUL_W'(crpm_pkg::CUR_GAIN));

  // stage 3: square
  assign s3_sq_full = s2_cur_r * s2_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_end_r <= 1'b0;
      s2_v_r   <= 1'b0;
      s2_end_r <= 1'b0;
      s3_v_r   <= 1'b0;
      s3_end_r <= 1'b0;
    end else begin
      s1_v_r   <= accept;
      s1_end_r <= accept && in_end;
      s2_v_r   <= s1_v_r;
      s2_end_r <= s1_end_r;
      s3_v_r   <= s2_v_r;
      s3_end_r <= s2_end_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_scaled_r <= s1_scaled;
    s2_cur_r    <= s2_cur_full[crpm_pkg::CUR_W-1:0];
    s3_cur_r    <= s2_cur_r;
    s3_sq_r     <= s3_sq_full[crpm_pkg::SQ_W-1:0];
  end

  // accumulate: signed peak compare, tie keeps the old peak
  assign s3_neg = -$signed((crpm_pkg::CUR_W+1)'(s3_cur_r));
  assign pos_gt = s3_cur_r > $signed({1'b0, peak_r});
  assign neg_gt = s3_neg > $signed({2'b00, peak_r});

  always_comb begin
    sum_nxt   = sum_r + SUM_W'(s3_sq_r);
    cnt_nxt   = cnt_r + 1'b1;
    tally_nxt = s3_cur_r[crpm_pkg::CUR_W-1] ? tally_r - TALLY_W'(1) : tally_r + TALLY_W'(1);
    peak_nxt  = peak_r;
    psign_nxt = psign_r;
    if (pos_gt) begin
      peak_nxt  = s3_cur_r[crpm_pkg::PEAK_W-1:0];
      psign_nxt = 1'b1;
    end else if (neg_gt) begin
      peak_nxt  = s3_neg[crpm_pkg::PEAK_W-1:0];
      psign_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      tally_r <= '0;
      peak_r  <= '0;
      psign_r <= 1'b0;
    end else if (s3_v_r) begin
      peak_r  <= peak_nxt;
      psign_r <= psign_nxt;
      if (s3_end_r) begin
        sum_r   <= '0;
        cnt_r   <= '0;
        tally_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
        tally_r <= tally_nxt;
      end
    end
  end

  // block package towards the back end
  assign job_push = s3_v_r && s3_end_r;
  assign job_data = {sum_nxt, cnt_nxt, !tally_nxt[TALLY_W-1], psign_nxt, peak_nxt};

  `CRPM_ASSERT(a_credit_bound, (q_stat.count + ends_in_flight) <= QEND_W'(crpm_pkg::QDEPTH), "block ends exceed queue room")
  `CRPM_ASSERT(a_end_has_valid, s3_end_r |-> s3_v_r, "block end without sample")

endmodule

### sv/crpm_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crpm_back #(
  parameter int CNT_W = 11,
  parameter int SUM_W = 47,
  parameter int JOB_W = 78
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  crpm_pkg::crpm_q_stat_t q_stat,
  input  logic [JOB_W-1:0]       job_data,
  output logic                   q_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output crpm_pkg::crpm_out_t    out_data
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam int SREM_W = crpm_pkg::ROOT_W + 2;
  localparam int CAND_W = crpm_pkg::ROOT_W + 4;

  crpm_pkg::crpm_bk_state_t state_r, state_nxt;

  logic [SUM_W-1:0]                  dq_r, dq_nxt;
  logic [CNT_W-1:0]                  div_r, div_nxt;
  logic [CNT_W-1:0]                  rem_r, rem_nxt;
  logic [crpm_pkg::MEAN_W-1:0]       v_r, v_nxt;
  logic [crpm_pkg::ROOT_W-1:0]       root_r, root_nxt;
  logic [SREM_W-1:0]                 srem_r, srem_nxt;
  logic [STEP_W-1:0]                 step_r, step_nxt;
  logic                              dir_r, dir_nxt;
  logic                              pdir_r, pdir_nxt;
  logic [crpm_pkg::PEAK_W-1:0]       peak_r, peak_nxt;
  logic [crpm_pkg::MUL_W-1:0]        pk_q_r, pk_q_nxt;
  logic [crpm_pkg::MUL_W-1:0]        rt_q_r, rt_q_nxt;
  logic                              out_v_r, out_v_nxt;
  crpm_pkg::crpm_out_t               out_r, out_nxt;

  logic [CNT_W:0]                    div_trial;
  logic                              div_ge;
  logic [CAND_W-1:0]                 sq_cand;
  logic [CAND_W-1:0]                 sq_trial;
  logic                              sq_ge;
  logic                              out_free;

  // restoring divide: one quotient bit per cycle
  assign div_trial = {rem_r, dq_r[SUM_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_r};

  // digit-by-digit root: two radicand bits per cycle
  assign sq_cand  = {srem_r, v_r[crpm_pkg::MEAN_W-1 -: 2]};
  assign sq_trial = CAND_W'({root_r, 2'b01});
  assign sq_ge    = sq_cand >= sq_trial;

  assign out_free  = !out_v_r || out_pop;
  assign out_empty = !out_v_r;
  assign out_data  = out_r;

  // sequencer and datapath next values
  always_comb begin
    state_nxt = state_r;
    dq_nxt    = dq_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    v_nxt     = v_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    pdir_nxt  = pdir_r;
    peak_nxt  = peak_r;
    pk_q_nxt  = pk_q_r;
    rt_q_nxt  = rt_q_r;
    out_v_nxt = out_v_r && !out_pop;
    out_nxt   = out_r;
    q_pop     = 1'b0;
    case (state_r)
      crpm_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          dq_nxt    = job_data[JOB_W-1 -: SUM_W];
          div_nxt   = job_data[crpm_pkg::PEAK_W+2 +: CNT_W];
          dir_nxt   = job_data[crpm_pkg::PEAK_W+1];
          pdir_nxt  = job_data[crpm_pkg::PEAK_W];
          peak_nxt  = job_data[crpm_pkg::PEAK_W-1:0];
          rem_nxt   = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = crpm_pkg::BK_DIV;
        end
      end
      crpm_pkg::BK_DIV: begin
        rem_nxt = div_ge ? CNT_W'(div_trial - {1'b0, div_r}) : div_trial[CNT_W-1:0];
        dq_nxt  = {dq_r[SUM_W-2:0], div_ge};
        if (step_r == '0) begin
          v_nxt     = dq_nxt[crpm_pkg::MEAN_W-1:0];
          root_nxt  = '0;
          srem_nxt  = '0;
          step_nxt  = STEP_W'(crpm_pkg::ROOT_W - 1);
          state_nxt = crpm_pkg::BK_ROOT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      crpm_pkg::BK_ROOT: begin
        v_nxt = {v_r[crpm_pkg::MEAN_W-3:0], 2'b00};
        if (sq_ge) begin
          srem_nxt = SREM_W'(sq_cand - sq_trial);
          root_nxt = {root_r[crpm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = sq_cand[SREM_W-1:0];
          root_nxt = {root_r[crpm_pkg::ROOT_W-2:0], 1'b0};
        end
        if (step_r == '0) begin
          state_nxt = crpm_pkg::BK_SCALE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      crpm_pkg::BK_SCALE: begin
        pk_q_nxt  = crpm_pkg::MUL_W'(peak_r) * crpm_pkg::MUL_W'(crpm_pkg::DIV100_MUL);
        rt_q_nxt  = crpm_pkg::MUL_W'(root_r) * crpm_pkg::MUL_W'(crpm_pkg::DIV100_MUL);
        state_nxt = crpm_pkg::BK_HOLD;
      end
      crpm_pkg::BK_HOLD: begin
        if (out_free) begin
          out_nxt.flow_dir    = dir_r;
          out_nxt.pk_dir      = pdir_r;
          out_nxt.pk_amps     = pk_q_r[crpm_pkg::DIV100_SHIFT +: crpm_pkg::PEAK_OUT_W];
          out_nxt.rms_current = rt_q_r[crpm_pkg::DIV100_SHIFT +: crpm_pkg::RMS_OUT_W];
          out_v_nxt           = 1'b1;
          state_nxt           = crpm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = crpm_pkg::BK_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crpm_pkg::BK_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    step_r <= step_nxt;
    dir_r  <= dir_nxt;
    pdir_r <= pdir_nxt;
    peak_r <= peak_nxt;
    pk_q_r <= pk_q_nxt;
    rt_q_r <= rt_q_nxt;
    out_r  <= out_nxt;
  end

  `CRPM_ASSERT(a_rem_below_div, (state_r == crpm_pkg::BK_DIV) |-> (rem_r < div_r), "divide remainder not below count")
  `CRPM_ASSERT(a_div_nonzero, (state_r == crpm_pkg::BK_DIV) |-> (div_r != '0), "block count of zero")

endmodule

### sv/current_rms_peak_meter.sv
`timescale 1ns / 1ps
// Channel   Ports                         Direction  Handshake
// ------------------------------------------------------------------------
// samples   in_push, in_full, in_data     in         push && !full
// packages  out_pop, out_empty, out_data  out        pop && !empty
//
// One sample is taken per cycle while in_full is low; the front pipe is three stages deep.
// Each block end takes the back end through a restoring divide, one bit a
// cycle, then the root, two bits a cycle, then the scale and hold states.
// Up to four block ends wait in the queue; in_full rises when all four slots
// are taken by queued or in-flight block ends.
// Synchronous active-low reset; the held peak is cleared only here.
// A stalled out_pop holds the package and backs up the queue, then in_full.
module current_rms_peak_meter #(
  parameter int MAX_BLOCK = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  crpm_pkg::crpm_in_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output crpm_pkg::crpm_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = crpm_pkg::SQ_W + CNT_W;
  localparam int JOB_W = SUM_W + CNT_W + 2 + crpm_pkg::PEAK_W;

  logic                   job_push;
  logic [JOB_W-1:0]       job_wdata;
  logic [JOB_W-1:0]       job_rdata;
  logic                   q_pop;
  crpm_pkg::crpm_q_stat_t q_stat;

  crpm_front #(
    .MAX_BLOCK (MAX_BLOCK),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .job_push (job_push),
    .job_data (job_wdata)
  );

  crpm_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wdata),
    .pop   (q_pop),
    .rdata (job_rdata),
    .stat  (q_stat)
  );

  crpm_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .JOB_W (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .job_data  (job_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
